### hdl/assert_macros.svh
// Assertion macros for the directory RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/scd_pkg.sv
// Types and constants of the sector cache directory.
package scd_pkg;

   localparam int ENTRIES     = 64;
   localparam int SECTOR_BITS = 32;
   localparam int IDX_W       = $clog2(ENTRIES);
   localparam int SLOT_W      = 6;
   localparam int SEC_W       = 32;

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_FLUSH = 2'd2;

   typedef struct packed {
      logic [1:0]       command;
      logic [SEC_W-1:0] sector;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              hit;
      logic              fetch_needed;
      logic              writeback_needed;
      logic [SEC_W-1:0]  writeback_sector;
      logic              last;
   } rsp_type;

   // one directory word per slot
   typedef struct packed {
      logic                   ref_bit;
      logic                   dirty;
      logic [SECTOR_BITS-1:0] tag;
   } word_type;

   typedef enum logic [1:0] {
      MODE_LOOKUP,
      MODE_SWEEP,
      MODE_FLUSH
   } mode_type;

   typedef struct packed {
      logic     match;
      logic     stop;
      logic     wb;
      logic     write_en;
      word_type wr_word;
   } step_type;

endpackage

### hdl/scd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/scd_step.sv
// Per-slot decision unit shared by lookup, clock sweep and flush scans.
module scd_step (
   input  scd_pkg::mode_type                   mode,
   input  logic                                slot_valid,
   input  scd_pkg::word_type                   word,
   input  logic [scd_pkg::SECTOR_BITS-1:0]     sector,
   input  logic                                is_write,
   output scd_pkg::step_type                   result
);

   always_comb begin
      result = '0;
      unique case (mode)
         scd_pkg::MODE_LOOKUP: begin
            result.match            = slot_valid && (word.tag == sector);
            result.stop             = result.match;
            result.write_en         = result.match;
            result.wr_word.ref_bit  = 1'b1;
            result.wr_word.dirty    = word.dirty | is_write;
            result.wr_word.tag      = word.tag;
         end
         scd_pkg::MODE_SWEEP: begin
            // empty slot or second chance used up: this is the victim
            result.stop     = !slot_valid || !word.ref_bit;
            result.wb       = slot_valid && word.dirty;
            result.write_en = 1'b1;
            if (result.stop) begin
               result.wr_word.ref_bit = 1'b1;
               result.wr_word.dirty   = is_write;
               result.wr_word.tag     = sector;
            end else begin
               result.wr_word.ref_bit = 1'b0;
               result.wr_word.dirty   = word.dirty;
               result.wr_word.tag     = word.tag;
            end
         end
         scd_pkg::MODE_FLUSH: begin
            result.match           = slot_valid && word.dirty;
            result.wb              = 1'b1;
            result.write_en        = result.match;
            result.wr_word.ref_bit = word.ref_bit;
            result.wr_word.dirty   = 1'b0;
            result.wr_word.tag     = word.tag;
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

### hdl/sector_cache_clock_directory_core.sv
// Top level of the sector cache directory: scan sequencer, slot RAM and valid bits.
//
// Fully associative directory with clock replacement for a write-back sector cache.
// Request channel (req_valid / req_stall / req_data) takes one transaction: read,
// write or flush. Result channel (rsp_valid / rsp_stall / rsp_data) returns one
// result per access, or one per dirty slot for a flush (last marks the final one;
// a flush with nothing dirty returns a single all-zero result with last set).
// Tag, dirty and reference bits live in one RAM word per slot; a single compare
// unit walks the slots one per cycle, pipelined against the registered RAM read
// (a flush re-reads a slot while its result cannot yet be passed on). A hit ends
// the lookup at its slot; a miss runs the full ENTRIES-slot lookup and then a
// sweep of 1 to ENTRIES+1 slots. A flush scans all ENTRIES slots and can be held
// back by result stalls. The RAM read port sets the pace of one slot per cycle.
// req_stall is high while a transaction is in progress; command 3 is taken
// and dropped. The result sits in an output register, so a stalled receiver
// does not block the next request, only the delivery of further results.
// Reset (synchronous) clears all valid bits, the clock hand and the channels;
// no clearing pass is needed.
module sector_cache_clock_directory_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  scd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output scd_pkg::rsp_type rsp_data
);

`include "assert_macros.svh"

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SWEEP,
      ST_FLUSH,
      ST_DONE
   } state_type;

   state_type                          state_ff, state_in;
   logic [scd_pkg::IDX_W-1:0]          idx_ff, idx_in;        // RAM read address
   logic [scd_pkg::IDX_W-1:0]          chk_idx_ff, chk_idx_in; // slot of rd_data
   logic                               chk_vld_ff, chk_vld_in;
   logic [1:0]                         cmd_ff, cmd_in;
   logic [scd_pkg::SECTOR_BITS-1:0]    sec_ff, sec_in;
   logic [scd_pkg::ENTRIES-1:0]        valid_ff, valid_in;
   logic [scd_pkg::IDX_W-1:0]          hand_ff, hand_in;
   scd_pkg::rsp_type                   pend_ff, pend_in;      // held result
   logic                               pend_vld_ff, pend_vld_in;
   scd_pkg::rsp_type                   rsp_ff, rsp_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   scd_pkg::word_type                  rd_word;
   logic                               ram_wr_en;
   scd_pkg::mode_type                  mode;
   scd_pkg::step_type                  step;
   logic                               out_free;
   logic [scd_pkg::IDX_W-1:0]          idx_next;
   scd_pkg::rsp_type                   flush_entry;

   scd_ram #(
      .WIDTH($bits(scd_pkg::word_type)),
      .DEPTH(scd_pkg::ENTRIES)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(chk_idx_ff),
      .wr_data(step.wr_word),
      .rd_addr(idx_ff),
      .rd_data(rd_word)
   );

   always_comb begin
      unique case (state_ff)
         ST_SWEEP: mode = scd_pkg::MODE_SWEEP;
         ST_FLUSH: mode = scd_pkg::MODE_FLUSH;
         default:  mode = scd_pkg::MODE_LOOKUP;
      endcase
   end

   scd_step u_step (
      .mode      (mode),
      .slot_valid(valid_ff[chk_idx_ff]),
      .word      (rd_word),
      .sector    (sec_ff),
      .is_write  (cmd_ff == scd_pkg::CMD_WRITE),
      .result    (step)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign idx_next = (idx_ff == scd_pkg::IDX_W'(scd_pkg::ENTRIES - 1)) ? '0 : idx_ff + 1'b1;

   always_comb begin
      flush_entry                  = '0;
      flush_entry.slot             = scd_pkg::SLOT_W'(chk_idx_ff);
      flush_entry.writeback_needed = 1'b1;
      flush_entry.writeback_sector = scd_pkg::SEC_W'(rd_word.tag);
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      chk_idx_in   = chk_idx_ff;
      chk_vld_in   = chk_vld_ff;
      cmd_in       = cmd_ff;
      sec_in       = sec_ff;
      valid_in     = valid_ff;
      hand_in      = hand_ff;
      pend_in      = pend_ff;
      pend_vld_in  = pend_vld_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_wr_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in      = req_data.command;
               sec_in      = req_data.sector[scd_pkg::SECTOR_BITS-1:0];
               idx_in      = '0;
               chk_vld_in  = 1'b0;
               pend_vld_in = 1'b0;
               if (req_data.command == scd_pkg::CMD_FLUSH) begin
                  state_in = ST_FLUSH;
               end else if (req_data.command == scd_pkg::CMD_READ ||
                            req_data.command == scd_pkg::CMD_WRITE) begin
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            idx_in     = idx_next;
            chk_idx_in = idx_ff;
            chk_vld_in = 1'b1;
            if (chk_vld_ff) begin
               if (step.match) begin
                  ram_wr_en    = 1'b1;
                  pend_in      = '0;
                  pend_in.slot = scd_pkg::SLOT_W'(chk_idx_ff);
                  pend_in.hit  = 1'b1;
                  pend_in.last = 1'b1;
                  pend_vld_in  = 1'b1;
                  chk_vld_in   = 1'b0;
                  state_in     = ST_DONE;
               end else if (chk_idx_ff == scd_pkg::IDX_W'(scd_pkg::ENTRIES - 1)) begin
                  // miss: restart the scan at the clock hand
                  idx_in     = hand_ff;
                  chk_vld_in = 1'b0;
                  state_in   = ST_SWEEP;
               end
            end
         end
         ST_SWEEP: begin
            idx_in     = idx_next;
            chk_idx_in = idx_ff;
            chk_vld_in = 1'b1;
            if (chk_vld_ff) begin
               ram_wr_en = 1'b1;   // clears a reference bit or fills the victim
               if (step.stop) begin
                  valid_in[chk_idx_ff] = 1'b1;
                  hand_in              = chk_idx_ff;
                  pend_in              = '0;
                  pend_in.slot         = scd_pkg::SLOT_W'(chk_idx_ff);
                  pend_in.fetch_needed = 1'b1;
                  pend_in.writeback_needed = step.wb;
                  pend_in.writeback_sector =
                     step.wb ? scd_pkg::SEC_W'(rd_word.tag) : '0;
                  pend_in.last         = 1'b1;
                  pend_vld_in          = 1'b1;
                  chk_vld_in           = 1'b0;
                  state_in             = ST_DONE;
               end
            end
         end
         ST_FLUSH: begin
            idx_in     = idx_next;
            chk_idx_in = idx_ff;
            chk_vld_in = 1'b1;
            if (chk_vld_ff) begin
               if (step.match && pend_vld_ff && !out_free) begin
                  // output busy: re-read this slot next cycle
                  idx_in     = chk_idx_ff;
                  chk_vld_in = 1'b0;
               end else begin
                  if (step.match) begin
                     ram_wr_en   = 1'b1;
                     pend_in     = flush_entry;
                     pend_vld_in = 1'b1;
                     if (pend_vld_ff) begin
                        rsp_in       = pend_ff;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  if (chk_idx_ff == scd_pkg::IDX_W'(scd_pkg::ENTRIES - 1)) begin
                     chk_vld_in = 1'b0;
                     state_in   = ST_DONE;
                  end
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_vld_ff ? pend_ff : '0;
               rsp_in.last  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         hand_ff      <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         chk_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         valid_ff     <= valid_in;
         hand_ff      <= hand_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         chk_idx_ff   <= chk_idx_in;
      end
      cmd_ff  <= cmd_in;
      sec_ff  <= sec_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_IMPLY(a_hit_clean, clock, reset, rsp_valid && rsp_data.hit,
                 !rsp_data.fetch_needed && !rsp_data.writeback_needed)
   `ASSERT_IMPLY(a_wbs_zero, clock, reset, rsp_valid && !rsp_data.writeback_needed,
                 rsp_data.writeback_sector == '0)
   `ASSERT_NEXT(a_fill_valid, clock, reset, state_ff == ST_SWEEP && chk_vld_ff && step.stop,
                valid_ff[hand_ff] && state_ff == ST_DONE)
   `ASSERT_IMPLY(a_wr_busy, clock, reset, ram_wr_en,
                 state_ff == ST_LOOKUP || state_ff == ST_SWEEP || state_ff == ST_FLUSH)

endmodule
